>>> hw/rtl/uirb_pkg.sv
package uirb_pkg;

	// default ring depth, entries per direction
	localparam int DEFAULT_DEPTH = 64;

	localparam int BYTE_W = 8;
	localparam int FUNC_W = 2;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TAKE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd2;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              tx_ready;
		logic              rx_ready;
		byte_t             rx_byte;
		byte_t             send_byte;
	} req_item_t;

endpackage

>>> hw/rtl/uirb_if.sv
interface uirb_in_if;
	import uirb_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic              tx_ready;
	logic              rx_ready;
	byte_t             rx_byte;
	byte_t             send_byte;

	modport source (output valid, func, tx_ready, rx_ready, rx_byte, send_byte, input ready);
	modport sink   (input valid, func, tx_ready, rx_ready, rx_byte, send_byte, output ready);
endinterface

interface uirb_out_if #(
	parameter int CW = $clog2(uirb_pkg::DEFAULT_DEPTH + 1)
);
	import uirb_pkg::*;

	logic          valid;
	logic          ready;
	logic          tx_valid;
	byte_t         tx_byte;
	logic          got_valid;
	byte_t         got_byte;
	logic          send_accepted;
	logic          rx_dropped;
	logic          tx_irq_enable;
	logic [CW-1:0] rx_fill;
	logic [CW-1:0] tx_fill;

	modport source (output valid, tx_valid, tx_byte, got_valid, got_byte, send_accepted,
		rx_dropped, tx_irq_enable, rx_fill, tx_fill, input ready);
	modport sink   (input valid, tx_valid, tx_byte, got_valid, got_byte, send_accepted,
		rx_dropped, tx_irq_enable, rx_fill, tx_fill, output ready);
endinterface

>>> hw/rtl/uirb_ram.sv
module uirb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/uirb_ctrl.sv
module uirb_ctrl #(
	parameter int BUFFER_DEPTH = uirb_pkg::DEFAULT_DEPTH,
	localparam int PW = $clog2(BUFFER_DEPTH),
	localparam int CW = $clog2(BUFFER_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	uirb_in_if.sink               req,
	uirb_out_if.source            rsp,
	output logic                  rx_we,
	output logic [PW-1:0]         rx_waddr,
	output uirb_pkg::byte_t       rx_wdata,
	output logic [PW-1:0]         rx_raddr,
	input  uirb_pkg::byte_t       rx_rdata,
	output logic                  tx_we,
	output logic [PW-1:0]         tx_waddr,
	output uirb_pkg::byte_t       tx_wdata,
	output logic [PW-1:0]         tx_raddr,
	input  uirb_pkg::byte_t       tx_rdata
);
	import uirb_pkg::*;

	localparam logic [PW-1:0] LAST_POS = PW'(BUFFER_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);

	logic          rx_en_q;
	logic [PW-1:0] rx_wpos_q, rx_rpos_q, tx_wpos_q, tx_rpos_q;
	logic [CW-1:0] rx_cnt_q, tx_cnt_q;
	logic          tx_irq_q;

	logic          valid_s1;
	req_item_t     item_s1;

	logic          out_valid_q;
	logic          out_tx_valid_q, out_got_valid_q, out_acc_q, out_drop_q;
	byte_t         out_tx_byte_q, out_got_byte_q;

	logic          done_s1;
	logic          is_event, is_take, is_put;
	logic          tx_serve, tx_pop, put_ok, rx_serve, rx_push, rx_drop, take_ok;
	logic [CW-1:0] rx_cnt_n, tx_cnt_n;
	logic          tx_irq_n;

	function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
		return (p == LAST_POS) ? '0 : p + PW'(1);
	endfunction

	// one request in flight: the ram read is issued at acceptance
	assign req.ready = !valid_s1;
	assign done_s1   = valid_s1 && (!out_valid_q || rsp.ready);

	always_comb begin
		is_event = (item_s1.func == FUNC_EVENT);
		is_take  = (item_s1.func == FUNC_TAKE);
		is_put   = (item_s1.func == FUNC_PUT);

		tx_serve = is_event && tx_irq_q && item_s1.tx_ready;
		tx_pop   = tx_serve && (tx_cnt_q != '0);
		put_ok   = is_put && (tx_cnt_q != FULL_CNT);
		rx_serve = is_event && rx_en_q && item_s1.rx_ready;
		rx_push  = rx_serve && (rx_cnt_q != FULL_CNT);
		rx_drop  = rx_serve && (rx_cnt_q == FULL_CNT);
		take_ok  = is_take && (rx_cnt_q != '0);

		tx_cnt_n = tx_cnt_q;
		if (tx_pop) begin
			tx_cnt_n = tx_cnt_q - CW'(1);
		end else if (put_ok) begin
			tx_cnt_n = tx_cnt_q + CW'(1);
		end

		rx_cnt_n = rx_cnt_q;
		if (take_ok) begin
			rx_cnt_n = rx_cnt_q - CW'(1);
		end else if (rx_push) begin
			rx_cnt_n = rx_cnt_q + CW'(1);
		end

		tx_irq_n = tx_irq_q;
		if (tx_serve && (tx_cnt_n == '0)) begin
			tx_irq_n = 1'b0;
		end else if (put_ok) begin
			tx_irq_n = 1'b1;
		end
	end

	assign rx_raddr = rx_rpos_q;
	assign tx_raddr = tx_rpos_q;
	assign rx_we    = done_s1 && rx_push;
	assign rx_waddr = rx_wpos_q;
	assign rx_wdata = item_s1.rx_byte;
	assign tx_we    = done_s1 && put_ok;
	assign tx_waddr = tx_wpos_q;
	assign tx_wdata = item_s1.send_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_en_q <= 1'b1;
		end else if (cfg_we) begin
			rx_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			rx_wpos_q   <= '0;
			rx_rpos_q   <= '0;
			tx_wpos_q   <= '0;
			tx_rpos_q   <= '0;
			rx_cnt_q    <= '0;
			tx_cnt_q    <= '0;
			tx_irq_q    <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			if (done_s1) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (done_s1) begin
				if (rx_push) rx_wpos_q <= next_pos(rx_wpos_q);
				if (take_ok) rx_rpos_q <= next_pos(rx_rpos_q);
				if (put_ok)  tx_wpos_q <= next_pos(tx_wpos_q);
				if (tx_pop)  tx_rpos_q <= next_pos(tx_rpos_q);
				rx_cnt_q <= rx_cnt_n;
				tx_cnt_q <= tx_cnt_n;
				tx_irq_q <= tx_irq_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.func      <= req.func;
			item_s1.tx_ready  <= req.tx_ready;
			item_s1.rx_ready  <= req.rx_ready;
			item_s1.rx_byte   <= req.rx_byte;
			item_s1.send_byte <= req.send_byte;
		end
		if (done_s1) begin
			out_tx_valid_q  <= tx_pop;
			out_tx_byte_q   <= tx_pop ? tx_rdata : '0;
			out_got_valid_q <= take_ok;
			out_got_byte_q  <= take_ok ? rx_rdata : '0;
			out_acc_q       <= put_ok;
			out_drop_q      <= rx_drop;
		end
	end

	// status fields follow the committed state
	assign rsp.valid         = out_valid_q;
	assign rsp.tx_valid      = out_tx_valid_q;
	assign rsp.tx_byte       = out_tx_byte_q;
	assign rsp.got_valid     = out_got_valid_q;
	assign rsp.got_byte      = out_got_byte_q;
	assign rsp.send_accepted = out_acc_q;
	assign rsp.rx_dropped    = out_drop_q;
	assign rsp.tx_irq_enable = tx_irq_q;
	assign rsp.rx_fill       = rx_cnt_q;
	assign rsp.tx_fill       = tx_cnt_q;

endmodule

>>> hw/rtl/uart_interrupt_ring_buffers.sv
// receive and transmit byte rings between a uart and software
//
// req channel: one request per handshake. func selects a uart event
// (send one queued byte if the transmit interrupt is on and the uart is
// ready, then store or drop a received byte), a take of the oldest
// received byte, or a put of a byte for sending (sets transmit enable if accepted).
// rsp channel: one result per request with flags, bytes and both fills.
// cfg_we/cfg_wdata write the receive interrupt enable, reset value 1.
//
// one request in flight: a new request is not taken until the last one
// has committed to the output register. the ring read is issued at
// acceptance and its data comes from the ram's registered port;
// the read-modify-write of pointers and ram then commits.
// a stalled rsp holds its result; one further request may be taken and
// waits in the working stage until the output register frees.
// reset clears pointers, counts and the transmit enable at once; ring
// contents are not cleared, so no clearing pass is needed.
module uart_interrupt_ring_buffers #(
	parameter int BUFFER_DEPTH = uirb_pkg::DEFAULT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	uirb_in_if.sink    req,
	uirb_out_if.source rsp
);
	import uirb_pkg::*;

	localparam int PW = $clog2(BUFFER_DEPTH);

	// receive ring port
	logic          rx_we;
	logic [PW-1:0] rx_waddr, rx_raddr;
	byte_t         rx_wdata, rx_rdata;
	// transmit ring port
	logic          tx_we;
	logic [PW-1:0] tx_waddr, tx_raddr;
	byte_t         tx_wdata, tx_rdata;

	// pointer, count and enable logic with the output register
	uirb_ctrl #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp),
		.rx_we    (rx_we),
		.rx_waddr (rx_waddr),
		.rx_wdata (rx_wdata),
		.rx_raddr (rx_raddr),
		.rx_rdata (rx_rdata),
		.tx_we    (tx_we),
		.tx_waddr (tx_waddr),
		.tx_wdata (tx_wdata),
		.tx_raddr (tx_raddr),
		.tx_rdata (tx_rdata)
	);

	// receive ring storage
	uirb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_waddr),
		.wdata(rx_wdata),
		.raddr(rx_raddr),
		.rdata(rx_rdata)
	);

	// transmit ring storage
	uirb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_waddr),
		.wdata(tx_wdata),
		.raddr(tx_raddr),
		.rdata(tx_rdata)
	);

endmodule

>>> hw/rtl/uirb_checker.sv
module uirb_checker #(
	parameter int BUFFER_DEPTH = uirb_pkg::DEFAULT_DEPTH,
	localparam int CW = $clog2(BUFFER_DEPTH + 1)
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  tx_valid,
	input uirb_pkg::byte_t       tx_byte,
	input logic                  got_valid,
	input uirb_pkg::byte_t       got_byte,
	input logic                  send_accepted,
	input logic                  tx_irq_enable,
	input logic [CW-1:0]         rx_fill,
	input logic [CW-1:0]         tx_fill
);

	localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_byte) && $stable(got_byte)
			&& $stable(rx_fill) && $stable(tx_fill))
	else $error("stalled result changed");

	// one request does one thing
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({tx_valid, got_valid, send_accepted}))
	else $error("result flags of different requests together");

	// bytes are zero unless their flag is set
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (tx_valid || tx_byte == '0) && (got_valid || got_byte == '0))
	else $error("byte without its flag");

	// empty transmit ring leaves the interrupt off, fills within depth
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (tx_fill != '0 || !tx_irq_enable)
			&& rx_fill <= FULL_CNT && tx_fill <= FULL_CNT)
	else $error("transmit enable or fill inconsistent");

endmodule

bind uart_interrupt_ring_buffers uirb_checker #(
	.BUFFER_DEPTH(BUFFER_DEPTH)
) u_uirb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.tx_valid     (rsp.tx_valid),
	.tx_byte      (rsp.tx_byte),
	.got_valid    (rsp.got_valid),
	.got_byte     (rsp.got_byte),
	.send_accepted(rsp.send_accepted),
	.tx_irq_enable(rsp.tx_irq_enable),
	.rx_fill      (rsp.rx_fill),
	.tx_fill      (rsp.tx_fill)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import uirb_pkg::*;

	localparam int DEPTH = DEFAULT_DEPTH;
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	// func code with no meaning, the block must leave its state alone
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// one result as seen on the rsp channel
	typedef struct packed {
		logic          tx_valid;
		byte_t         tx_byte;
		logic          got_valid;
		byte_t         got_byte;
		logic          send_accepted;
		logic          rx_dropped;
		logic          tx_irq_enable;
		logic [CW-1:0] rx_fill;
		logic [CW-1:0] tx_fill;
	} ring_result_t;

	// a scripted request; known rows carry a hand-written result
	typedef struct {
		req_item_t    rq;
		bit           known;
		ring_result_t want;
	} script_row_t;

	// shapes of random traffic, chosen per burst
	typedef enum int {
		FILL_RX,
		FILL_TX,
		DRAIN,
		MIXED
	} traffic_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	uirb_in_if req_if ();
	uirb_out_if #(.CW(CW)) rsp_if ();

	uart_interrupt_ring_buffers #(
		.BUFFER_DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	always #1 clk = ~clk;

	// our own copy of both rings, their pointers and the interrupt flags
	byte_t rx_ring [DEPTH];
	byte_t tx_ring [DEPTH];
	int    rx_wr = 0;
	int    rx_rd = 0;
	int    rx_cnt = 0;
	int    tx_wr = 0;
	int    tx_rd = 0;
	int    tx_cnt = 0;
	bit    tx_irq = 1'b0;
	bit    rx_irq_en = 1'b1;

	// results still owed by the block, oldest first
	ring_result_t pending_results [$];
	script_row_t  script [$];

	int          errors = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int unsigned cycles = 0;

	// works out the result of one request and moves the rings on
	task automatic advance_rings(input req_item_t rq, output ring_result_t r);
		r = '0;
		case (rq.func)
			FUNC_EVENT: begin
				// transmitter is served first
				if (tx_irq && rq.tx_ready) begin
					if (tx_cnt > 0) begin
						r.tx_valid = 1'b1;
						r.tx_byte = tx_ring[PW'(tx_rd)];
						tx_rd = (tx_rd + 1) % DEPTH;
						tx_cnt--;
					end
					// queue emptied, or already empty: interrupt off
					if (tx_cnt == 0)
						tx_irq = 1'b0;
				end
				if (rx_irq_en && rq.rx_ready) begin
					if (rx_cnt < DEPTH) begin
						rx_ring[PW'(rx_wr)] = rq.rx_byte;
						rx_wr = (rx_wr + 1) % DEPTH;
						rx_cnt++;
					end else begin
						r.rx_dropped = 1'b1;
					end
				end
			end
			FUNC_TAKE: begin
				if (rx_cnt > 0) begin
					r.got_valid = 1'b1;
					r.got_byte = rx_ring[PW'(rx_rd)];
					rx_rd = (rx_rd + 1) % DEPTH;
					rx_cnt--;
				end
			end
			FUNC_PUT: begin
				// a full queue refuses the byte and leaves the enable as it was
				if (tx_cnt < DEPTH) begin
					tx_ring[PW'(tx_wr)] = rq.send_byte;
					tx_wr = (tx_wr + 1) % DEPTH;
					tx_cnt++;
					tx_irq = 1'b1;
					r.send_accepted = 1'b1;
				end
			end
			default: ;
		endcase
		r.tx_irq_enable = tx_irq;
		r.rx_fill = CW'(rx_cnt);
		r.tx_fill = CW'(tx_cnt);
	endtask

	function automatic req_item_t mk_req(logic [FUNC_W-1:0] f, bit txr, bit rxr,
			byte_t rb, byte_t sb);
		req_item_t rq;
		rq.func = f;
		rq.tx_ready = txr;
		rq.rx_ready = rxr;
		rq.rx_byte = rb;
		rq.send_byte = sb;
		return rq;
	endfunction

	function automatic ring_result_t known_result(bit tv, byte_t tb, bit gv, byte_t gb,
			bit acc, bit drop, bit irq, int rxf, int txf);
		ring_result_t r;
		r.tx_valid = tv;
		r.tx_byte = tb;
		r.got_valid = gv;
		r.got_byte = gb;
		r.send_accepted = acc;
		r.rx_dropped = drop;
		r.tx_irq_enable = irq;
		r.rx_fill = CW'(rxf);
		r.tx_fill = CW'(txf);
		return r;
	endfunction

	task automatic add_row(req_item_t rq, bit known, ring_result_t want);
		script_row_t row;
		row.rq = rq;
		row.known = known;
		row.want = want;
		script.push_back(row);
	endtask

	// random request; the mode biases traffic so the rings fill up and empty out
	function automatic req_item_t random_req(traffic_mode_t mode);
		int w_ev;
		int w_tk;
		int w_pt;
		int p_tx;
		int p_rx;
		int roll;
		req_item_t rq;
		case (mode)
			FILL_RX: begin
				w_ev = 75; w_tk = 10; w_pt = 13; p_tx = 30; p_rx = 90;
			end
			FILL_TX: begin
				w_ev = 18; w_tk = 10; w_pt = 70; p_tx = 20; p_rx = 50;
			end
			DRAIN: begin
				w_ev = 45; w_tk = 45; w_pt = 8; p_tx = 90; p_rx = 15;
			end
			default: begin
				w_ev = 40; w_tk = 28; w_pt = 28; p_tx = 50; p_rx = 50;
			end
		endcase
		roll = $urandom_range(99);
		rq.tx_ready = ($urandom_range(99) < p_tx);
		rq.rx_ready = ($urandom_range(99) < p_rx);
		rq.rx_byte = byte_t'($urandom);
		rq.send_byte = byte_t'($urandom);
		if (roll < w_ev)
			rq.func = FUNC_EVENT;
		else if (roll < w_ev + w_tk)
			rq.func = FUNC_TAKE;
		else if (roll < w_ev + w_tk + w_pt)
			rq.func = FUNC_PUT;
		else
			rq.func = FUNC_UNUSED;
		return rq;
	endfunction

	// presents one request and waits for the handshake; valid stays high after
	// acceptance so back-to-back requests need no gap
	task automatic send_req(req_item_t rq, bit known, ring_result_t want);
		ring_result_t predicted;
		if ($urandom_range(99) < idle_pct) begin
			req_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_if.valid <= 1'b1;
		req_if.func <= rq.func;
		req_if.tx_ready <= rq.tx_ready;
		req_if.rx_ready <= rq.rx_ready;
		req_if.rx_byte <= rq.rx_byte;
		req_if.send_byte <= rq.send_byte;
		do @(posedge clk); while (!req_if.ready);
		advance_rings(rq, predicted);
		pending_results.push_back(known ? want : predicted);
	endtask

	task automatic run_traffic(int n);
		int left;
		int burst;
		traffic_mode_t mode;
		req_item_t rq;
		left = n;
		burst = 0;
		mode = MIXED;
		while (left > 0) begin
			if (burst == 0) begin
				burst = $urandom_range(120, 40);
				mode = traffic_mode_t'($urandom_range(3));
			end
			rq = random_req(mode);
			send_req(rq, 1'b0, '0);
			burst--;
			// unused codes are ignored by the block, so they do not count
			if (rq.func != FUNC_UNUSED)
				left--;
		end
	endtask

	// drop valid and let every owed result come back, plus a little slack
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_rx_enable(bit en);
		cfg_we <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		rx_irq_en = en;
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned actual);
		if (want != actual) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
				actual);
			errors++;
		end
	endtask

	// receiver side: random back-pressure and the check of every result
	initial begin
		ring_result_t seen;
		ring_result_t want;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				seen.tx_valid = rsp_if.tx_valid;
				seen.tx_byte = rsp_if.tx_byte;
				seen.got_valid = rsp_if.got_valid;
				seen.got_byte = rsp_if.got_byte;
				seen.send_accepted = rsp_if.send_accepted;
				seen.rx_dropped = rsp_if.rx_dropped;
				seen.tx_irq_enable = rsp_if.tx_irq_enable;
				seen.rx_fill = rsp_if.rx_fill;
				seen.tx_fill = rsp_if.tx_fill;
				if (pending_results.size() == 0) begin
					$display("%0t: result with no request waiting, expected none, actual %p",
						$time, seen);
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("tx_valid", want.tx_valid, seen.tx_valid);
					check_field("tx_byte", want.tx_byte, seen.tx_byte);
					check_field("got_valid", want.got_valid, seen.got_valid);
					check_field("got_byte", want.got_byte, seen.got_byte);
					check_field("send_accepted", want.send_accepted, seen.send_accepted);
					check_field("rx_dropped", want.rx_dropped, seen.rx_dropped);
					check_field("tx_irq_enable", want.tx_irq_enable, seen.tx_irq_enable);
					check_field("rx_fill", want.rx_fill, seen.rx_fill);
					check_field("tx_fill", want.tx_fill, seen.tx_fill);
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog against a hung handshake
	initial begin
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		ring_result_t idle_result;
		idle_result = '0;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.func <= FUNC_EVENT;
		req_if.tx_ready <= 1'b0;
		req_if.rx_ready <= 1'b0;
		req_if.rx_byte <= '0;
		req_if.send_byte <= '0;

		// directed requests straight after reset, receive enable still 1
		// take from an empty ring
		add_row(mk_req(FUNC_TAKE, 0, 0, 8'h00, 8'h00), 1'b1, idle_result);
		// uart ready to send but the transmit interrupt is still off
		add_row(mk_req(FUNC_EVENT, 1, 0, 8'hFF, 8'hFF), 1'b1, idle_result);
		// unused code with every other field high changes nothing
		add_row(mk_req(FUNC_UNUSED, 1, 1, 8'hFF, 8'hFF), 1'b1, idle_result);
		// event with neither flag
		add_row(mk_req(FUNC_EVENT, 0, 0, 8'hFF, 8'hFF), 1'b1, idle_result);
		// two received bytes at the byte extremes
		add_row(mk_req(FUNC_EVENT, 0, 1, 8'hFF, 8'h00), 1'b1,
			known_result(0, 8'h00, 0, 8'h00, 0, 0, 0, 1, 0));
		add_row(mk_req(FUNC_EVENT, 0, 1, 8'h00, 8'hFF), 1'b1,
			known_result(0, 8'h00, 0, 8'h00, 0, 0, 0, 2, 0));
		// two puts at the extremes switch the transmit interrupt on
		add_row(mk_req(FUNC_PUT, 1, 1, 8'h00, 8'hFF), 1'b1,
			known_result(0, 8'h00, 0, 8'h00, 1, 0, 1, 2, 1));
		add_row(mk_req(FUNC_PUT, 0, 0, 8'hFF, 8'h00), 1'b1,
			known_result(0, 8'h00, 0, 8'h00, 1, 0, 1, 2, 2));
		// oldest received byte comes out first
		add_row(mk_req(FUNC_TAKE, 1, 1, 8'h00, 8'h00), 1'b1,
			known_result(0, 8'h00, 1, 8'hFF, 0, 0, 1, 1, 2));
		// send and receive in one event
		add_row(mk_req(FUNC_EVENT, 1, 1, 8'h5A, 8'h00), 1'b0, idle_result);
		// last queued byte goes out and the transmit interrupt drops
		add_row(mk_req(FUNC_EVENT, 1, 0, 8'h00, 8'h5A), 1'b0, idle_result);
		add_row(mk_req(FUNC_TAKE, 0, 0, 8'h00, 8'h00), 1'b0, idle_result);
		add_row(mk_req(FUNC_TAKE, 0, 0, 8'h00, 8'h00), 1'b0, idle_result);
		add_row(mk_req(FUNC_TAKE, 1, 1, 8'hFF, 8'hFF), 1'b0, idle_result);
		add_row(mk_req(FUNC_PUT, 0, 0, 8'hFF, 8'hA5), 1'b0, idle_result);
		add_row(mk_req(FUNC_UNUSED, 0, 0, 8'h00, 8'h00), 1'b0, idle_result);
		// interrupt on but uart not ready: byte stays queued
		add_row(mk_req(FUNC_EVENT, 0, 1, 8'h81, 8'h00), 1'b0, idle_result);
		add_row(mk_req(FUNC_EVENT, 1, 0, 8'h00, 8'h00), 1'b0, idle_result);
		add_row(mk_req(FUNC_EVENT, 1, 0, 8'h00, 8'h00), 1'b0, idle_result);
		add_row(mk_req(FUNC_PUT, 0, 0, 8'h00, 8'h7E), 1'b0, idle_result);
		add_row(mk_req(FUNC_PUT, 0, 0, 8'h00, 8'h81), 1'b0, idle_result);
		add_row(mk_req(FUNC_EVENT, 1, 1, 8'h7E, 8'h81), 1'b0, idle_result);
		add_row(mk_req(FUNC_TAKE, 0, 0, 8'h00, 8'h00), 1'b0, idle_result);
		add_row(mk_req(FUNC_TAKE, 0, 0, 8'h00, 8'h00), 1'b0, idle_result);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_req(script[i].rq, script[i].known, script[i].want);

		// random part, one phase per idling pattern; each phase runs with
		// receive enabled, then a shorter stretch with it switched off
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 80; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 80; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			wait_idle();
			write_rx_enable(1'b1);
			run_traffic(260);
			wait_idle();
			write_rx_enable(1'b0);
			run_traffic(60);
		end

		wait_idle();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
